// File: hdl/msmp_pkg.sv
// ----------------------------------------------------------------------------
// msmp_pkg
// Shared types and constants for the minimum-difficulty job schedule block:
// field widths, result status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package msmp_pkg;

  // Field widths fixed by the stream format
  localparam int JOB_W       = 10;
  localparam int TOTAL_W     = 14;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes
  localparam status_t STATUS_OK  = 2'd0;
  localparam status_t STATUS_FEW = 2'd1;
  localparam status_t STATUS_OVF = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // job transfer on the input stream
    logic set_err;   // latch an error result
    logic sfx_init;  // start the one-day suffix-max pass
    logic sfx_rd;    // read job[i] for the suffix pass
    logic sfx_wr;    // fold into running max, write cost row
    logic row_init;  // start the next day count
    logic in_rd;     // read job[j] and cost[prev][j+1]
    logic in_acc;    // fold one candidate split
    logic in_wr;     // write best cost for start i
    logic fin_rd;    // read final cost[prev][0]
    logic fin_ld;    // latch the final total
    logic emit;      // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad;       // overflow or too few jobs
    logic i_zero;    // suffix index reached 0
    logic days_one;  // a single day requested
    logic j_end;     // last split point for this start
    logic i_end;     // last start index for this row
    logic k_end;     // last day count done
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/msmp_ctrl.sv
// ----------------------------------------------------------------------------
// msmp_ctrl
// Sequencer for the job schedule block: loads jobs, then walks the suffix pass,
// the per-day DP rows and the final read, then emits; an error run goes straight to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module msmp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  input  wire logic           s_axis_tlast,
  output logic                s_axis_tready,
  input  wire msmp_pkg::sts_t sts_i,
  output msmp_pkg::cmd_t      cmd_o
);

  typedef enum logic [10:0] {
    S_LOAD     = 11'b000_0000_0001,
    S_DECIDE   = 11'b000_0000_0010,
    S_SFX_RD   = 11'b000_0000_0100,
    S_SFX_WR   = 11'b000_0000_1000,
    S_ROW_INIT = 11'b000_0001_0000,
    S_IN_RD    = 11'b000_0010_0000,
    S_IN_ACC   = 11'b000_0100_0000,
    S_IN_WR    = 11'b000_1000_0000,
    S_FIN_RD   = 11'b001_0000_0000,
    S_FIN_LD   = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tlast) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.bad) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_EMIT;
        end else begin
          cmd_o.sfx_init = 1'b1;
          state_d        = S_SFX_RD;
        end
      end
      S_SFX_RD: begin
        cmd_o.sfx_rd = 1'b1;
        state_d      = S_SFX_WR;
      end
      S_SFX_WR: begin
        cmd_o.sfx_wr = 1'b1;
        priority if (!sts_i.i_zero) begin
          state_d = S_SFX_RD;
        end else if (sts_i.days_one) begin
          state_d = S_FIN_RD;
        end else begin
          state_d = S_ROW_INIT;
        end
      end
      S_ROW_INIT: begin
        cmd_o.row_init = 1'b1;
        state_d        = S_IN_RD;
      end
      S_IN_RD: begin
        cmd_o.in_rd = 1'b1;
        state_d     = S_IN_ACC;
      end
      S_IN_ACC: begin
        cmd_o.in_acc = 1'b1;
        state_d      = sts_i.j_end ? S_IN_WR : S_IN_RD;
      end
      S_IN_WR: begin
        cmd_o.in_wr = 1'b1;
        priority if (!sts_i.i_end) begin
          state_d = S_IN_RD;
        end else if (sts_i.k_end) begin
          state_d = S_FIN_RD;
        end else begin
          state_d = S_ROW_INIT;
        end
      end
      S_FIN_RD: begin
        cmd_o.fin_rd = 1'b1;
        state_d      = S_FIN_LD;
      end
      S_FIN_LD: begin
        cmd_o.fin_ld = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/msmp_dp.sv
// ----------------------------------------------------------------------------
// msmp_dp
// Datapath: job store, two rolling cost rows in one memory, loop counters,
// the max/add/min step and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module msmp_dp #(
  parameter int MAX_JOBS  = 256,
  parameter int MAX_DAYS  = 16,
  parameter int DIFF_BITS = 10
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [msmp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                                 cfg_we_i,
  input  wire logic [msmp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire logic                                 m_axis_tready,
  output logic                                      m_axis_tvalid,
  output logic [msmp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic [msmp_pkg::STATUS_W-1:0]             m_axis_tuser,
  input  wire msmp_pkg::cmd_t                       cmd_i,
  output msmp_pkg::sts_t                            sts_o
);

  localparam int SW = (DIFF_BITS < msmp_pkg::JOB_W) ? DIFF_BITS : msmp_pkg::JOB_W;
  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int NW = $clog2(MAX_JOBS + 1);
  localparam int DW = $clog2(MAX_DAYS + 1);
  localparam int CW = $clog2(MAX_DAYS * ((1 << SW) - 1) + 1);

  // Memories
  logic [SW-1:0] job_mem  [MAX_JOBS];
  logic [CW-1:0] cost_mem [2*MAX_JOBS];

  // Registers
  logic [msmp_pkg::CFG_W-1:0] cfg_q;
  logic [NW-1:0]              count_q;
  logic                       ovf_q;
  logic [IW-1:0]              i_q, j_q, lim_q;
  logic [DW-1:0]              k_q;
  logic                       prev_q;
  logic [SW-1:0]              run_q;
  logic                       run_first_q;
  logic [SW-1:0]              seg_q;
  logic [CW-1:0]              best_q;
  logic                       best_v_q;
  logic [SW-1:0]              job_rd_q;
  logic [CW-1:0]              cost_rd_q;
  msmp_pkg::total_t           res_total_q, out_total_q;
  msmp_pkg::status_t          res_status_q, out_status_q;
  logic                       out_valid_q;

  logic [DW-1:0]              days_eff;
  logic                       few;
  logic [SW-1:0]              run_d;
  logic [SW-1:0]              seg_d;
  logic [CW-1:0]              cand;
  logic [IW-1:0]              job_raddr;
  logic [IW:0]                cost_raddr;
  logic [IW:0]                cost_waddr;
  logic [CW-1:0]              cost_wdata;
  logic                       cost_we;

  // Effective day count: zero reads as one, large values saturate
  always_comb begin
    priority if (cfg_q == '0) begin
      days_eff = DW'(1);
    end else if (int'(cfg_q) > MAX_DAYS) begin
      days_eff = DW'(MAX_DAYS);
    end else begin
      days_eff = DW'(cfg_q);
    end
  end

  assign few = (int'(count_q) < int'(days_eff));

  // Suffix running max and DP candidate
  assign run_d = (run_first_q || (job_rd_q > run_q)) ? job_rd_q : run_q;
  assign seg_d = (job_rd_q > seg_q) ? job_rd_q : seg_q;
  assign cand  = CW'(seg_d) + cost_rd_q;

  // Memory addresses
  assign job_raddr  = cmd_i.sfx_rd ? i_q : j_q;
  assign cost_raddr = cmd_i.in_rd ? {prev_q, IW'(j_q + IW'(1))} : {prev_q, {IW{1'b0}}};
  assign cost_we    = cmd_i.sfx_wr || cmd_i.in_wr;
  assign cost_waddr = cmd_i.sfx_wr ? {prev_q, i_q} : {~prev_q, i_q};
  assign cost_wdata = cmd_i.sfx_wr ? CW'(run_d) : best_q;

  // Job store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (int'(count_q) < MAX_JOBS)) begin
      job_mem[count_q[IW-1:0]] <= s_axis_tdata[SW-1:0];
    end
    if (cmd_i.sfx_rd || cmd_i.in_rd) begin
      job_rd_q <= job_mem[job_raddr];
    end
  end

  // Cost rows
  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    if (cmd_i.in_rd || cmd_i.fin_rd) begin
      cost_rd_q <= cost_mem[cost_raddr];
    end
  end

  // Configuration, fill count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= msmp_pkg::CFG_W'(1);
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (int'(count_q) < MAX_JOBS) begin
          count_q <= NW'(count_q + NW'(1));
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // Loop counters and DP accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.sfx_init) begin
      i_q         <= IW'(count_q - NW'(1));
      prev_q      <= 1'b0;
      k_q         <= DW'(1);
      run_first_q <= 1'b1;
    end
    if (cmd_i.sfx_wr) begin
      run_q       <= run_d;
      run_first_q <= 1'b0;
      if (i_q != '0) begin
        i_q <= IW'(i_q - IW'(1));
      end
    end
    if (cmd_i.row_init) begin
      k_q      <= DW'(k_q + DW'(1));
      lim_q    <= IW'(count_q - NW'(k_q + DW'(1)));
      i_q      <= '0;
      j_q      <= '0;
      seg_q    <= '0;
      best_v_q <= 1'b0;
    end
    if (cmd_i.in_acc) begin
      seg_q    <= seg_d;
      best_v_q <= 1'b1;
      if (!best_v_q || (cand < best_q)) begin
        best_q <= cand;
      end
      if (j_q != lim_q) begin
        j_q <= IW'(j_q + IW'(1));
      end
    end
    if (cmd_i.in_wr) begin
      if (i_q == lim_q) begin
        prev_q <= ~prev_q;
      end else begin
        i_q      <= IW'(i_q + IW'(1));
        j_q      <= IW'(i_q + IW'(1));
        seg_q    <= '0;
        best_v_q <= 1'b0;
      end
    end
  end

  // Pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_err) begin
      res_total_q  <= '0;
      res_status_q <= ovf_q ? msmp_pkg::STATUS_OVF : msmp_pkg::STATUS_FEW;
    end else if (cmd_i.fin_ld) begin
      res_total_q  <= msmp_pkg::total_t'(cost_rd_q);
      res_status_q <= msmp_pkg::STATUS_OK;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_total_q  <= res_total_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(msmp_pkg::OUT_TDATA_W - msmp_pkg::TOTAL_W){1'b0}}, out_total_q};
  assign m_axis_tuser  = out_status_q;

  // Status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.bad      = ovf_q || few;
    sts_o.i_zero   = (i_q == '0);
    sts_o.days_one = (days_eff == DW'(1));
    sts_o.j_end    = (j_q == lim_q);
    sts_o.i_end    = (i_q == lim_q);
    sts_o.k_end    = (k_q == days_eff);
    sts_o.out_free = !out_valid_q || m_axis_tready;
  end

endmodule

`default_nettype wire

// File: hdl/min_sum_of_segment_max_partition.sv
// ----------------------------------------------------------------------------
// min_sum_of_segment_max_partition
// Loads a run of job difficulties, then finds the split into the configured
// number of contiguous days that minimizes the sum of per-day maxima.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid / tready        | tdata[9:0] job_difficulty, tlast last_job
//  m_axis    | out | tvalid / tready        | tdata[13:0] min_total, tuser status
//  cfg       | in  | cfg_we_i               | cfg_wdata_i day_count
//
//  Jobs load at one transfer per cycle into the job store while the input is open.
//  After the last transfer the DP runs on one job-store read port, with a read
//  state and an accumulate state for each inner step.
//  Input is not accepted from the last transfer until the result is latched in
//  the output register; a stalled result holds and blocks only the next result.
//  Reset clears control state only; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module min_sum_of_segment_max_partition #(
  parameter int MAX_JOBS  = 256,
  parameter int MAX_DAYS  = 16,
  parameter int DIFF_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [msmp_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [9:0] job_difficulty
  input  wire logic                            s_axis_tlast,   // last_job
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [msmp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [13:0] min_total
  output logic [msmp_pkg::STATUS_W-1:0]        m_axis_tuser,   // [1:0] status
  input  wire logic                            cfg_we_i,
  input  wire logic [msmp_pkg::CFG_W-1:0]      cfg_wdata_i     // day_count
);

  msmp_pkg::cmd_t cmd;
  msmp_pkg::sts_t sts;

  // Sequencer
  msmp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Stores, counters and arithmetic
  msmp_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .MAX_DAYS  (MAX_DAYS),
    .DIFF_BITS (DIFF_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

// File: hdl/msmp_chk.sv
// ----------------------------------------------------------------------------
// msmp_chk
// Port-level checks for the job schedule block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msmp_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            s_axis_tlast,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [msmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [msmp_pkg::STATUS_W-1:0]    m_axis_tuser
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == msmp_pkg::STATUS_OK ||
                       m_axis_tuser == msmp_pkg::STATUS_FEW ||
                       m_axis_tuser == msmp_pkg::STATUS_OVF))
    else $error("undefined status code");

  // An error result carries a zero total
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != msmp_pkg::STATUS_OK) |->
      (m_axis_tdata == '0))
    else $error("error result with nonzero total");

  // The last job closes the input
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last job");

endmodule

bind min_sum_of_segment_max_partition msmp_chk u_msmp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_sum_of_segment_max_partition. Job runs go in
// on the input stream, and a behavioral scheduler in the bench predicts each
// run's minimum total and status. Every output transfer is checked against
// the oldest prediction. The bench covers day-count limits, the store
// filling up, overflow, and random runs with random idle and stall gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_JOBS  = 256;
  localparam int MAX_DAYS  = 16;
  localparam int DIFF_BITS = 10;

  localparam int JOB_W       = msmp_pkg::JOB_W;
  localparam int CFG_W       = msmp_pkg::CFG_W;
  localparam int STATUS_W    = msmp_pkg::STATUS_W;
  localparam int IN_TDATA_W  = msmp_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = msmp_pkg::OUT_TDATA_W;

  typedef msmp_pkg::total_t  total_t;
  typedef msmp_pkg::status_t status_t;

  typedef enum int {MIX_FULL, MIX_LOW, MIX_EDGE} job_mix_e;

  typedef struct {
    total_t  total;
    status_t status;
  } sched_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]     m_axis_tuser;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i   = '0;

  // Scheduler state mirrored in the bench
  logic [JOB_W-1:0] job_buf [MAX_JOBS];
  int               job_cnt   = 0;
  bit               store_ovf = 1'b0;
  logic [CFG_W-1:0] day_reg   = 5'd1;

  sched_result_t expected_results [$];
  int            mismatch_count = 0;
  bit            gaps_on  = 1'b1;
  bit            stall_on = 1'b1;
  int unsigned   ready_hold = 0;

  min_sum_of_segment_max_partition #(
    .MAX_JOBS  (MAX_JOBS),
    .MAX_DAYS  (MAX_DAYS),
    .DIFF_BITS (DIFF_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Smallest sum of per-day maxima over splits of job_buf[0..n-1] into days runs
  function automatic total_t min_day_split(int n, int days);
    int row_cost [MAX_JOBS+1];
    int next_cost [MAX_JOBS+1];
    int peak;
    int best;
    int cand;
    peak = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (job_buf[i] > peak) peak = job_buf[i];
      row_cost[i] = peak;
    end
    for (int k = 2; k <= days; k++) begin
      for (int i = 0; i <= n - k; i++) begin
        peak = 0;
        best = 32'h7fff_ffff;
        for (int j = i; j <= n - k; j++) begin
          if (job_buf[j] > peak) peak = job_buf[j];
          cand = peak + row_cost[j+1];
          if (cand < best) best = cand;
        end
        next_cost[i] = best;
      end
      for (int i = 0; i <= n - k; i++) row_cost[i] = next_cost[i];
    end
    return total_t'(row_cost[0]);
  endfunction

  // Update the mirrored state for one accepted job transfer
  function automatic void track_job(logic [JOB_W-1:0] diff, bit last);
    sched_result_t r;
    int eff_days;
    if (job_cnt < MAX_JOBS) begin
      job_buf[job_cnt] = diff;
      job_cnt++;
    end else begin
      store_ovf = 1'b1;
    end
    if (!last) return;
    eff_days = (day_reg == 0) ? 1 : (day_reg > MAX_DAYS) ? MAX_DAYS : int'(day_reg);
    r.total = '0;
    if (store_ovf) begin
      r.status = msmp_pkg::STATUS_OVF;
    end else if (job_cnt < eff_days) begin
      r.status = msmp_pkg::STATUS_FEW;
    end else begin
      r.status = msmp_pkg::STATUS_OK;
      r.total  = min_day_split(job_cnt, eff_days);
    end
    expected_results.push_back(r);
    job_cnt   = 0;
    store_ovf = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [JOB_W-1:0] pick_job(job_mix_e mix);
    case (mix)
      MIX_LOW:  return JOB_W'($urandom_range(0, 7));
      MIX_EDGE: return ($urandom_range(0, 1) ? 10'h3ff : 10'h000) ^ JOB_W'($urandom_range(0, 1));
      default:  return JOB_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // One job transfer, with an optional idle gap in front
  task automatic send_job(logic [JOB_W-1:0] diff, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(diff);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_job(diff, last);
  endtask

  task automatic send_run(int len, job_mix_e mix);
    for (int i = 0; i < len; i++) send_job(pick_job(mix), i == len - 1);
  endtask

  // Hold off input until every predicted result is out, then let the block settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_days(logic [CFG_W-1:0] days);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= days;
    @(posedge clk_i);
    day_reg = days;
    cfg_we_i <= 1'b0;
  endtask

  // Day count left at its reset value of one
  task automatic test_reset_days();
    send_job(10'h3ff, 1'b1);
    send_job(10'h000, 1'b1);
    send_job(10'h000, 1'b0);
    send_job(10'h3ff, 1'b0);
    send_job(10'h200, 1'b1);
  endtask

  // Exactly as many jobs as days, too few jobs, and a day count of zero
  task automatic test_job_count_edges();
    write_days(5'd3);
    send_job(10'd5, 1'b0);
    send_job(10'h3ff, 1'b0);
    send_job(10'd0, 1'b1);
    send_job(10'd7, 1'b0);
    send_job(10'd9, 1'b1);
    write_days(5'd0);
    send_job(10'd3, 1'b0);
    send_job(10'h3ff, 1'b0);
    send_job(10'd2, 1'b1);
  endtask

  // Largest day count, and counts above it that saturate
  task automatic test_day_limits();
    write_days(5'd16);
    for (int i = 0; i < 16; i++) send_job(10'h3ff, i == 15);
    write_days(5'd31);
    send_run(16, MIX_FULL);
    send_run(15, MIX_LOW);
    write_days(5'd17);
    send_run(20, MIX_EDGE);
  endtask

  // Store filled exactly, then overrun so the last job is dropped
  task automatic test_store_limits();
    write_days(5'd2);
    send_run(MAX_JOBS, MIX_FULL);
    send_run(MAX_JOBS + 1, MIX_LOW);
    send_run(4, MIX_FULL);
  endtask

  task automatic test_random_runs();
    int sent;
    int quota;
    int len;
    int r;
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      r = $urandom_range(0, 9);
      write_days((r < 2) ? CFG_W'($urandom_range(0, 31)) : CFG_W'($urandom_range(1, 8)));
      gaps_on  = (phase != 2);
      stall_on = (phase != 3);
      quota = sent + 25;
      while (sent < quota) begin
        r = $urandom_range(0, 99);
        len = (r < 75) ? $urandom_range(1, 12) : $urandom_range(13, 32);
        send_run(len, job_mix_e'($urandom_range(0, 2)));
        sent += len;
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Output stall pattern: runs of ready or not ready, mostly short
  always @(posedge clk_i) begin
    if (!stall_on) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
      ready_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    sched_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected result total=%0d status=%0d",
                   $realtime, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(exp_r.total) || m_axis_tuser !== exp_r.status) begin
          if (mismatch_count < 10)
            $display("%0t: result mismatch total exp=%0d act=%0d status exp=%0d act=%0d",
                     $realtime, exp_r.total, m_axis_tdata, exp_r.status, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_days();
    test_job_count_edges();
    test_day_limits();
    test_store_limits();
    test_random_runs();
    wait_drain();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
